// ===== design/min_tracking_fifo_queue_assert.svh =====
// Assertion macros shared by the min-tracking queue RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef MIN_TRACKING_FIFO_QUEUE_ASSERT_SVH
`define MIN_TRACKING_FIFO_QUEUE_ASSERT_SVH

// expr must hold at every clock edge
`define MTFQ_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("mtfq assertion failed");

// cons must hold in the same cycle as ante
`define MTFQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtfq assertion failed");

// cons must hold in the cycle after ante
`define MTFQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtfq assertion failed");

`endif

// ===== design/mtfq_pkg.sv =====
// Package for the min-tracking queue: word types, request codes, constants
// and the controller/datapath command and status structs. No dependencies.
`default_nettype none

package mtfq_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int DATA_W    = 64;
  localparam int COUNT_W   = 11;

  localparam logic signed [DATA_W-1:0] MIN_RESET = {1'b0, {(DATA_W-1){1'b1}}};

  localparam logic [1:0] REQ_QUERY = 2'd0;
  localparam logic [1:0] REQ_ENQ   = 2'd1;
  localparam logic [1:0] REQ_DEQ   = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic                     status;
    logic signed [DATA_W-1:0] value_out;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] min_value;
    logic                     empty_res;
  } res_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/mtfq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mtfq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/mtfq_ctrl.sv =====
// Controller for the min-tracking queue: sequences accept, execute,
// minimum rescan and result load. Depends on mtfq_pkg.
`default_nettype none

module mtfq_ctrl import mtfq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire logic       res_valid,
  input  wire logic       res_ready,
  input  wire dp_status_t stat,
  output ctrl_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_ready  = (state == S_IDLE);
  assign cmd.accept = req_valid && req_ready;
  assign cmd.exec   = (state == S_EXEC);
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.load   = (state == S_DONE) && (!res_valid || res_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = stat.need_scan ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (cmd.load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/mtfq_dp.sv =====
// Datapath for the min-tracking queue: pointers, occupancy, running minimum,
// rescan counters, entry RAM and result register. Depends on mtfq_pkg, mtfq_ram.
`default_nettype none
`include "min_tracking_fifo_queue_assert.svh"

module mtfq_dp import mtfq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire req_t      req,
  input  wire ctrl_cmd_t cmd,
  output dp_status_t     stat,
  input  wire logic      res_ready,
  output logic           res_valid,
  output res_t           res
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [AW-1:0]    LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  logic [AW-1:0]            head;
  logic [AW-1:0]            tail;
  logic [CNT_W-1:0]         occ;
  logic signed [DATA_W-1:0] cur_min;
  logic [1:0]               op;
  logic signed [DATA_W-1:0] val;
  logic                     r_status;
  logic signed [DATA_W-1:0] r_vout;
  logic [AW-1:0]            scan_ptr;
  logic [CNT_W-1:0]         scan_left;
  logic                     scan_pend;

  logic [AW-1:0]            head_inc;
  logic [AW-1:0]            tail_inc;
  logic [AW-1:0]            scan_inc;
  logic [CNT_W-1:0]         occ_dec;
  logic                     q_empty;
  logic                     is_full;
  logic                     ram_we;
  logic [AW-1:0]            ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rd_word;

  assign head_inc  = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign tail_inc  = (tail == LAST_SLOT) ? '0 : tail + 1'b1;
  assign scan_inc  = (scan_ptr == LAST_SLOT) ? '0 : scan_ptr + 1'b1;
  assign occ_dec   = occ - 1'b1;
  assign q_empty   = (occ == '0);
  assign is_full   = (occ == FULL_CNT);
  assign rd_word   = $signed(ram_rdata);
  assign ram_we    = cmd.exec && (op == REQ_ENQ) && !is_full;
  assign ram_raddr = cmd.scan ? scan_ptr : head;

  assign stat.need_scan = (op == REQ_DEQ) && !q_empty && (occ_dec != '0) &&
                          (rd_word == cur_min);
  assign stat.scan_done = cmd.scan && (scan_left == '0) && !scan_pend;

  mtfq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail),
    .wdata(val),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op  <= req.req_type;
      val <= req.value_in;
    end
    if (cmd.exec) begin
      r_status <= ST_OK;
      r_vout   <= '0;
      unique case (op)
        REQ_QUERY, REQ_DEQ: begin
          if (q_empty) begin
            r_status <= ST_ERR;
          end else begin
            r_vout <= rd_word;
          end
        end
        REQ_ENQ: begin
          if (is_full) r_status <= ST_ERR;
        end
        REQ_CLEAR: begin
        end
        default: begin
        end
      endcase
    end
    if (cmd.load) begin
      res.status    <= r_status;
      res.value_out <= r_vout;
      res.count     <= COUNT_W'(occ);
      res.min_value <= q_empty ? '0 : cur_min;
      res.empty_res <= q_empty;
    end
  end

  // queue state and minimum rescan
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      cur_min   <= MIN_RESET;
      scan_ptr  <= '0;
      scan_left <= '0;
      scan_pend <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        unique case (op)
          REQ_ENQ: begin
            if (!is_full) begin
              tail <= tail_inc;
              occ  <= occ + 1'b1;
              if (val < cur_min) cur_min <= val;
            end
          end
          REQ_DEQ: begin
            if (!q_empty) begin
              head <= head_inc;
              occ  <= occ_dec;
              if (occ_dec == '0) begin
                cur_min <= MIN_RESET;
              end else if (stat.need_scan) begin
                cur_min   <= MIN_RESET;
                scan_ptr  <= head_inc;
                scan_left <= occ_dec;
                scan_pend <= 1'b0;
              end
            end
          end
          REQ_CLEAR: begin
            head    <= '0;
            tail    <= '0;
            occ     <= '0;
            cur_min <= MIN_RESET;
          end
          REQ_QUERY: begin
          end
          default: begin
          end
        endcase
      end
      if (cmd.scan) begin
        // one read issued per cycle, compared in the following cycle
        if (scan_left != '0) begin
          scan_ptr  <= scan_inc;
          scan_left <= scan_left - 1'b1;
          scan_pend <= 1'b1;
        end else begin
          scan_pend <= 1'b0;
        end
        if (scan_pend && (rd_word < cur_min)) cur_min <= rd_word;
      end
      if (cmd.load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  `MTFQ_ASSERT_ALWAYS(a_occ_bound, occ <= FULL_CNT)
  `MTFQ_ASSERT_IMPL(a_empty_res, res_valid && res.empty_res, res.min_value == '0 && res.count == '0)
  `MTFQ_ASSERT_NEXT(a_scan_min_reset, cmd.exec && stat.need_scan, cur_min == MIN_RESET)

endmodule

`default_nettype wire

// ===== design/min_tracking_fifo_queue.sv =====
// Top level of the min-tracking queue: controller, datapath and entry RAM.
// Depends on mtfq_pkg, mtfq_ctrl, mtfq_dp.
//
// Usage: requests arrive on req (req_valid/req_ready), one word each: query,
// enqueue, dequeue or clear. Every request gives exactly one result word on
// res (res_valid/res_ready) with status, popped or front value, count,
// current minimum and empty flag.
// Timing: an accepted request passes through the execute and done states, and
// the result word is registered on load. When a dequeue removes the current
// minimum, a rescan state comes between them: it walks the remaining entries
// through the RAM read port, one per cycle. A new request is accepted only
// once the previous one has loaded its result, so one request is in flight.
// Reset (rst, synchronous) empties the queue and sets the minimum to the
// largest positive value; the RAM is not cleared and needs no init pass.
// If the receiver stalls, the finished result waits in the output register;
// one further request is accepted and executed, then held until it drains.
`default_nettype none
`include "min_tracking_fifo_queue_assert.svh"

module min_tracking_fifo_queue import mtfq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  mtfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mtfq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cmd      (cmd),
    .stat     (stat),
    .res_ready(res_ready),
    .res_valid(res_valid),
    .res      (res)
  );

  `MTFQ_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
  `MTFQ_ASSERT_IMPL(a_no_overwrite, cmd.load, !res_valid || res_ready)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for min_tracking_fifo_queue. It drives directed and random
// request words, and a queue model checks every result word. Depends on mtfq_pkg.

module tb;
  import mtfq_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;
  localparam int RANDOM_WORDS = 553;
  localparam logic signed [DATA_W-1:0] VAL_MAX = MIN_RESET;
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  req_t pending_reqs[$];
  res_t expected_res[$];
  int   fail_count = 0;
  int   gen_occ = 0;

  logic signed [DATA_W-1:0] model_store [QDEPTH];
  int model_head = 0;
  int model_tail = 0;
  int model_occ = 0;
  logic signed [DATA_W-1:0] model_min = MIN_RESET;

  min_tracking_fifo_queue #(.DEPTH(QDEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic res_t predict_response(req_t r);
    res_t rr;
    int   idx;
    int   k;
    rr = '0;
    rr.status = ST_OK;
    case (r.req_type)
      REQ_QUERY: begin
        if (model_occ == 0) rr.status = ST_ERR;
        else rr.value_out = model_store[model_head];
      end
      REQ_ENQ: begin
        if (model_occ >= QDEPTH) begin
          rr.status = ST_ERR;
        end else begin
          model_store[model_tail] = r.value_in;
          model_tail = (model_tail + 1) % QDEPTH;
          model_occ++;
          if ($signed(r.value_in) < $signed(model_min)) model_min = r.value_in;
        end
      end
      REQ_DEQ: begin
        if (model_occ == 0) begin
          rr.status = ST_ERR;
        end else begin
          rr.value_out = model_store[model_head];
          model_head = (model_head + 1) % QDEPTH;
          model_occ--;
          if (model_occ == 0) begin
            model_min = MIN_RESET;
          end else if (rr.value_out == model_min) begin
            model_min = MIN_RESET;
            idx = model_head;
            for (k = 0; k < model_occ; k++) begin
              if ($signed(model_store[idx]) < $signed(model_min)) model_min = model_store[idx];
              idx = (idx + 1) % QDEPTH;
            end
          end
        end
      end
      default: begin
        model_head = 0;
        model_tail = 0;
        model_occ = 0;
        model_min = MIN_RESET;
      end
    endcase
    rr.count = COUNT_W'(model_occ);
    rr.min_value = (model_occ == 0) ? '0 : model_min;
    rr.empty_res = (model_occ == 0);
    return rr;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    int s;
    s = $urandom_range(0, 9);
    if (s == 0) begin
      case ($urandom_range(0, 5))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return '0;
        3: return '1;
        4: return VAL_MIN + 1;
        default: return VAL_MAX - 1;
      endcase
    end else if (s < 5) begin
      s = $urandom_range(0, 16);
      s = s - 8;
      return DATA_W'(s);
    end
    return {$urandom, $urandom};
  endfunction

  task automatic push_req(logic [1:0] op, logic signed [DATA_W-1:0] v);
    req_t r;
    r.req_type = op;
    r.value_in = v;
    pending_reqs.push_back(r);
    case (op)
      REQ_ENQ: if (gen_occ < QDEPTH) gen_occ++;
      REQ_DEQ: if (gen_occ > 0) gen_occ--;
      REQ_CLEAR: gen_occ = 0;
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic signed [DATA_W-1:0] want,
                             logic signed [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // request driver
  int send_gap = 0;
  int send_burst = 0;
  always @(posedge clk) begin : drive
    int gap;
    if (rst) begin
      req_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_valid && req_ready) expected_res.push_back(predict_response(req));
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          if (send_burst > 0) begin
            send_burst--;
            gap = 0;
          end else if ($urandom_range(0, 24) == 0) begin
            send_burst = $urandom_range(10, 40);
            gap = 0;
          end else begin
            gap = $urandom_range(0, 12);
          end
          send_gap <= gap;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor; long hold-offs let the block back up into its input
  int recv_gap = 0;
  int recv_burst = 0;
  int hold_left = 0;
  int words_seen = 0;
  always @(posedge clk) begin : watch
    res_t want;
    logic next_ready;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      next_ready = res_ready;
      if (res_valid && res_ready) begin
        words_seen++;
        if (expected_res.size() == 0) begin
          $error("result word with no request outstanding");
          fail_count++;
        end else begin
          want = expected_res.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(res.status));
          check_field("value_out", want.value_out, res.value_out);
          check_field("count", DATA_W'(want.count), DATA_W'(res.count));
          check_field("min_value", want.min_value, res.min_value);
          check_field("empty_res", DATA_W'(want.empty_res), DATA_W'(res.empty_res));
        end
        if (words_seen % 900 == 60) begin
          hold_left = 400;
          recv_gap = 0;
        end else if (recv_burst > 0) begin
          recv_burst--;
          recv_gap = 0;
        end else if ($urandom_range(0, 24) == 0) begin
          recv_burst = $urandom_range(10, 40);
          recv_gap = 0;
        end else begin
          recv_gap = $urandom_range(0, 12);
        end
        next_ready = (recv_gap == 0) && (hold_left == 0);
      end else if (!res_ready) begin
        if (hold_left > 0) hold_left--;
        else if (recv_gap > 0) recv_gap--;
        next_ready = (recv_gap == 0) && (hold_left == 0);
      end
      res_ready <= next_ready;
    end
  end

  initial begin
    int n;
    int mode;
    int phase_left;
    int grow;
    int pick;
    logic [1:0] op;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] ramp;

    // directed words
    push_req(REQ_QUERY, rand_value());
    push_req(REQ_DEQ, rand_value());
    push_req(REQ_CLEAR, rand_value());
    push_req(REQ_ENQ, 64'sd5);
    push_req(REQ_QUERY, '0);
    push_req(REQ_ENQ, VAL_MAX);
    push_req(REQ_ENQ, VAL_MIN);
    push_req(REQ_ENQ, '1);
    push_req(REQ_ENQ, '0);
    push_req(REQ_ENQ, VAL_MIN);
    push_req(REQ_QUERY, '0);
    repeat (7) push_req(REQ_DEQ, '0);
    push_req(REQ_ENQ, 64'sd7);
    push_req(REQ_ENQ, 64'sd3);
    push_req(REQ_ENQ, 64'sd9);
    push_req(REQ_DEQ, '0);
    push_req(REQ_DEQ, '0);
    push_req(REQ_CLEAR, '0);
    push_req(REQ_QUERY, '0);
    push_req(REQ_ENQ, 64'hAAAA_AAAA_AAAA_AAAA);
    push_req(REQ_ENQ, 64'h5555_5555_5555_5555);

    // random phases: grow, shrink, balanced, grow with non-decreasing values
    phase_left = 0;
    mode = 0;
    ramp = '0;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (phase_left == 0) begin
        mode = $urandom_range(0, 3);
        if (mode == 1 && gen_occ < 4) mode = 0;
        phase_left = $urandom_range(20, 70);
        ramp = rand_value();
        if (ramp > 64'sd1000000 || ramp < -64'sd1000000) ramp = '0;
      end
      phase_left--;
      grow = (mode == 0 || mode == 3) ? 70 : (mode == 1) ? 20 : 45;
      pick = $urandom_range(0, 99);
      if (pick < 2) op = REQ_CLEAR;
      else if (pick < 10) op = REQ_QUERY;
      else if (pick < 10 + grow) op = REQ_ENQ;
      else op = REQ_DEQ;
      if (mode == 3 && op == REQ_ENQ) begin
        ramp = ramp + $urandom_range(0, 3);
        v = ramp;
      end else begin
        v = rand_value();
      end
      push_req(op, v);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || req_valid || expected_res.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(150_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
